/* rtl/tpc_pkg.sv */
package tpc_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int ALPHABET   = 256;
    localparam int COUNT_BITS = 32;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SYM_W     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int CT_AW     = NODE_W + SYM_W;
    localparam int CT_DEPTH  = MAX_NODES * (2 ** SYM_W);
    localparam int USED_W    = NODE_W + 1;
    localparam int CNT_EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    typedef logic [NODE_W-1:0]     t_node;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_CLEARED = 2'd2
    } t_status;

    typedef struct packed {
        t_op        op;
        logic [7:0] sym;
        logic       last;
    } t_item;

    // head of the item queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    typedef struct packed {
        logic sweeping;
    } t_back_stat;

    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == {COUNT_BITS{1'b1}}) ? v : v + t_count'(1);
        return r;
    endfunction

    function automatic logic [31:0] clamp_out(input t_count v);
        logic [CNT_EXT_W-1:0] w;
        logic [31:0]          r;
        w = CNT_EXT_W'(v);
        if (w > CNT_EXT_W'(33'h0_FFFF_FFFF)) begin
            r = 32'hFFFF_FFFF;
        end else begin
            r = w[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/tpc_front.sv */
module tpc_front
    import tpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_symbol,
    input  logic       i_last,
    input  t_back_stat i_back_stat,
    input  logic       i_pop,
    output t_qhead     o_head
);

    t_item      r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       full;
    logic       push;
    logic       pop;

    assign full = (r_cnt == 2'd2);
    assign busy = full | i_back_stat.sweeping;
    // unused opcode is taken and dropped here
    assign push = start & ~busy & (t_op'(i_opcode) != OP_NONE);
    assign pop  = i_pop & (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{op: t_op'(i_opcode), sym: i_symbol, last: i_last};
        end
    end

endmodule

/* rtl/tpc_back.sv */
module tpc_back
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qhead      i_head,
    output logic        o_pop,
    output t_back_stat  o_stat,
    output logic        o_valid,
    output logic [31:0] o_prefix_count,
    output logic [1:0]  o_status
);

    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_COUNT = 4'b1000
    } t_state;

    logic [NODE_W-1:0] ct_mem  [CT_DEPTH];
    t_count            cnt_mem [MAX_NODES];

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    t_node              r_cursor, n_cursor;
    logic [USED_W-1:0]  r_used, n_used;
    logic               r_miss, n_miss;
    logic               r_full, n_full;
    logic [CT_AW-1:0]   r_sweep_addr, n_sweep_addr;
    logic               r_sweep_rsp, n_sweep_rsp;
    t_node              r_child_rd;
    t_count             r_cnt_rd;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_count, n_out_count;
    t_status            r_out_status, n_out_status;

    logic               ct_we;
    logic [CT_AW-1:0]   ct_waddr, ct_raddr;
    t_node              ct_wdata;
    logic               cnt_we;
    t_node              cnt_waddr, cnt_raddr;
    t_count             cnt_wdata;

    logic               head_ins, head_sym_ok, item_ins;
    logic [CT_AW-1:0]   item_addr;
    t_count             inc;

    assign head_ins    = (i_head.item.op == OP_INSERT);
    assign head_sym_ok = ({1'b0, i_head.item.sym} < 9'(ALPHABET));
    assign item_ins    = (r_item.op == OP_INSERT);
    assign item_addr   = {r_cursor, r_item.sym[SYM_W-1:0]};
    assign inc         = sat_inc(r_cnt_rd);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_cursor     = r_cursor;
        n_used       = r_used;
        n_miss       = r_miss;
        n_full       = r_full;
        n_sweep_addr = r_sweep_addr;
        n_sweep_rsp  = r_sweep_rsp;
        n_out_valid  = 1'b0;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        ct_we        = 1'b0;
        ct_waddr     = item_addr;
        ct_wdata     = r_used[NODE_W-1:0];
        ct_raddr     = {r_cursor, i_head.item.sym[SYM_W-1:0]};
        cnt_we       = 1'b0;
        cnt_waddr    = r_cursor;
        cnt_wdata    = inc;
        cnt_raddr    = r_child_rd;

        case (r_state)
            S_SWEEP: begin
                ct_we    = 1'b1;
                ct_waddr = r_sweep_addr;
                ct_wdata = '0;
                if (r_sweep_addr == {CT_AW{1'b1}}) begin
                    n_state = S_IDLE;
                    if (r_sweep_rsp) begin
                        n_out_valid  = 1'b1;
                        n_out_count  = '0;
                        n_out_status = STAT_CLEARED;
                    end
                end else begin
                    n_sweep_addr = r_sweep_addr + CT_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_item = i_head.item;
                    case (i_head.item.op)
                        OP_CLEAR: begin
                            n_state      = S_SWEEP;
                            n_sweep_addr = '0;
                            n_sweep_rsp  = 1'b1;
                            n_used       = USED_W'(1);
                            n_cursor     = '0;
                            n_miss       = 1'b0;
                            n_full       = 1'b0;
                        end
                        OP_INSERT, OP_QUERY: begin
                            if (r_miss || r_full || !head_sym_ok) begin
                                // no walk: string already dead or symbol outside alphabet
                                if (!r_miss && !r_full) begin
                                    n_full = head_ins;
                                    n_miss = ~head_ins;
                                end
                                if (i_head.item.last) begin
                                    n_out_valid  = 1'b1;
                                    n_out_count  = '0;
                                    n_out_status = (head_ins && (n_full || r_full)) ?
                                                   STAT_FULL : STAT_OK;
                                    n_cursor     = '0;
                                    n_miss       = 1'b0;
                                    n_full       = 1'b0;
                                end
                            end else begin
                                n_state = S_EVAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (r_child_rd == '0) begin
                    if (!item_ins) begin
                        n_miss = 1'b1;
                    end else if (r_used == USED_W'(MAX_NODES)) begin
                        n_full = 1'b1;
                    end else begin
                        // new node: link it and start its count at one
                        ct_we     = 1'b1;
                        cnt_we    = 1'b1;
                        cnt_waddr = r_used[NODE_W-1:0];
                        cnt_wdata = t_count'(1);
                        n_cursor  = r_used[NODE_W-1:0];
                        n_used    = r_used + USED_W'(1);
                    end
                    if (r_item.last) begin
                        n_out_valid  = 1'b1;
                        n_out_count  = '0;
                        n_out_status = STAT_OK;
                        if (item_ins && r_used == USED_W'(MAX_NODES)) begin
                            n_out_status = STAT_FULL;
                        end else if (item_ins) begin
                            n_out_count = 32'd1;
                        end
                        n_cursor = '0;
                        n_miss   = 1'b0;
                        n_full   = 1'b0;
                    end
                end else begin
                    n_cursor = r_child_rd;
                    if (item_ins || r_item.last) begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                n_state = S_IDLE;
                if (item_ins) begin
                    cnt_we = 1'b1;
                end
                if (r_item.last) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = clamp_out(item_ins ? inc : r_cnt_rd);
                    n_out_status = STAT_OK;
                    n_cursor     = '0;
                    n_miss       = 1'b0;
                    n_full       = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_cursor     <= '0;
            r_used       <= USED_W'(1);
            r_miss       <= 1'b0;
            r_full       <= 1'b0;
            r_sweep_addr <= '0;
            r_sweep_rsp  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_used       <= n_used;
            r_miss       <= n_miss;
            r_full       <= n_full;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_rsp  <= n_sweep_rsp;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (ct_we) begin
            ct_mem[ct_waddr] <= ct_wdata;
        end
        r_child_rd <= ct_mem[ct_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= cnt_mem[cnt_raddr];
    end

    assign o_stat.sweeping = (r_state == S_SWEEP);
    assign o_valid         = r_out_valid;
    assign o_prefix_count  = r_out_count;
    assign o_status        = r_out_status;

endmodule

/* rtl/trie_prefix_counter_top.sv */
// Path of a last byte to its result strobe: the 2-entry queue, the idle state, the
// evaluate and count states where needed, then the result registers; bytes ahead go first.
// Bytes are walked one at a time, paced by the child table read followed by
// the count memory read-modify-write; a 2-entry queue lets bytes keep coming.
// Clear and reset: a sweep zeroes the child table, all its MAX_NODES * 2**SYM_W
// (262144) entries; busy is high throughout, only a clear gives a result; no receiver stall.
module trie_prefix_counter_top
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    output logic        o_valid,
    output logic [31:0] o_prefix_count,
    output logic [1:0]  o_status
);

    // front end: takes transfers, drops the unused opcode, queues the rest
    t_qhead     head;
    logic       pop;
    t_back_stat back_stat;

    tpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .i_back_stat (back_stat),
        .i_pop       (pop),
        .o_head      (head)
    );

    // back end: walks the trie one byte at a time, owns both memories,
    // and runs the clearing sweep
    tpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_stat         (back_stat),
        .o_valid        (o_valid),
        .o_prefix_count (o_prefix_count),
        .o_status       (o_status)
    );

endmodule

/* dv/trie_prefix_counter_top_tb.sv */
`timescale 1ns / 100ps

module trie_prefix_counter_top_tb;
    import tpc_pkg::*;

    // Slowest run: three sweeps of the child table (reset and two clears)
    // plus about 1300 transfers, each with the longest gap and walk.
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [31:0] count;
        t_status     status;
    } t_answer;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = OP_INSERT;
    logic [7:0]  i_symbol = '0;
    logic        i_last   = 1'b0;
    logic        o_valid;
    logic [31:0] o_prefix_count;
    logic [1:0]  o_status;

    trie_prefix_counter_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_symbol       (i_symbol),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_prefix_count (o_prefix_count),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow trie. Edges are kept sparse, keyed by node * ALPHABET + symbol;
    // a missing key is an absent edge.
    // ------------------------------------------------------------------
    t_node  kid_of [int];
    t_count tally [MAX_NODES];
    int     nodes_taken;
    t_node  cur_node;
    bit     walk_missed;
    bit     walk_full;

    t_answer pending_answers [$];

    int errors      = 0;
    int cycle_count = 0;
    int sent_total  = 0;
    int checked     = 0;
    int full_seen   = 0;
    int clears_seen = 0;
    int burst_left  = 0;
    bit gapless     = 1'b0;

    function automatic void wipe_trie();
        kid_of.delete();
        foreach (tally[n]) tally[n] = '0;
        nodes_taken = 1;
        cur_node    = '0;
        walk_missed = 1'b0;
        walk_full   = 1'b0;
    endfunction

    // Advances the shadow trie by one byte; returns 1 when a result is due.
    function automatic bit walk_trie(input t_op op, input logic [7:0] sym,
                                     input logic lst, output t_answer ans);
        int          slot;
        bit          moved;
        logic [63:0] wide;
        ans   = '0;
        moved = 1'b0;
        if (op == OP_CLEAR) begin
            wipe_trie();
            ans.status = STAT_CLEARED;
            return 1'b1;
        end
        if (op == OP_NONE)
            return 1'b0;
        // once a walk has stopped, the rest of the string is dead
        if (!walk_missed && !walk_full) begin
            slot = int'(cur_node) * ALPHABET + int'(sym);
            if (int'(sym) >= ALPHABET) begin
                if (op == OP_INSERT)
                    walk_full = 1'b1;
                else
                    walk_missed = 1'b1;
            end else if (kid_of.exists(slot)) begin
                cur_node = kid_of[slot];
                moved    = 1'b1;
            end else if (op == OP_QUERY) begin
                walk_missed = 1'b1;
            end else if (nodes_taken >= MAX_NODES) begin
                walk_full = 1'b1;
            end else begin
                kid_of[slot] = t_node'(nodes_taken);
                nodes_taken++;
                cur_node = kid_of[slot];
                moved    = 1'b1;
            end
            if (moved && op == OP_INSERT && tally[cur_node] != '1)
                tally[cur_node] += 1;
        end
        if (!lst)
            return 1'b0;
        if (walk_missed || walk_full) begin
            ans.count = '0;
        end else begin
            wide      = 64'(tally[cur_node]);
            ans.count = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end
        ans.status  = (op == OP_INSERT && walk_full) ? STAT_FULL : STAT_OK;
        cur_node    = '0;
        walk_missed = 1'b0;
        walk_full   = 1'b0;
        return 1'b1;
    endfunction

    function automatic void flag_error(input string what);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("[%0t] ERROR: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Sender. Bursts of random length, random gaps between them; gapless
    // stretches when requested. start stays high across back-to-back
    // transfers and is only lowered by hold_off.
    // ------------------------------------------------------------------
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_byte(input t_op op, input logic [7:0] sym, input logic lst);
        t_answer ans;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!gapless && $urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 7));
        end
        burst_left--;
        start    <= 1'b1;
        i_opcode <= op;
        i_symbol <= sym;
        i_last   <= lst;
        // busy as seen at the edge decides the transfer
        do @(posedge i_clk); while (busy);
        sent_total++;
        if (walk_trie(op, sym, lst, ans)) begin
            pending_answers = {pending_answers, ans};
            if (ans.status == STAT_FULL)
                full_seen++;
            if (ans.status == STAT_CLEARED)
                clears_seen++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result check: every strobe is taken, oldest expectation first.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                flag_error($sformatf("unexpected result: count %0d status %0d",
                                     o_prefix_count, o_status));
            end else begin
                want = pending_answers.pop_front();
                checked++;
                if (o_prefix_count !== want.count)
                    flag_error($sformatf("prefix count: expected %0d, got %0d",
                                         want.count, o_prefix_count));
                if (o_status !== want.status)
                    flag_error($sformatf("status: expected %0d, got %0d",
                                         want.status, o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_answers.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        gapless = 1'b0;
        send_byte(OP_QUERY,  8'h61, 1'b1);   // empty trie: miss
        send_byte(OP_INSERT, 8'h00, 1'b1);
        send_byte(OP_INSERT, 8'hFF, 1'b1);
        send_byte(OP_INSERT, 8'h00, 1'b0);
        send_byte(OP_INSERT, 8'hFF, 1'b1);   // deeper node, root child now at 2
        send_byte(OP_QUERY,  8'h00, 1'b1);
        send_byte(OP_QUERY,  8'h00, 1'b0);
        send_byte(OP_NONE,   8'hA5, 1'b1);   // ignored, string carries on
        send_byte(OP_QUERY,  8'hFF, 1'b1);
        send_byte(OP_QUERY,  8'hFF, 1'b0);
        send_byte(OP_QUERY,  8'h00, 1'b1);   // edge missing below FF
        send_byte(OP_INSERT, 8'h00, 1'b0);   // mixed string over shared cursor
        send_byte(OP_QUERY,  8'hFF, 1'b0);
        send_byte(OP_INSERT, 8'h5A, 1'b1);
        send_byte(OP_QUERY,  8'h42, 1'b0);   // miss ...
        send_byte(OP_INSERT, 8'h42, 1'b1);   // ... blocks the insert: 0, ok
        send_byte(OP_INSERT, 8'h7E, 1'b0);
        send_byte(OP_CLEAR,  8'h00, 1'b0);   // clear in the middle of a string
        send_byte(OP_QUERY,  8'h00, 1'b1);
        send_byte(OP_INSERT, 8'h7E, 1'b1);
        send_byte(OP_QUERY,  8'h7E, 1'b1);
        send_byte(OP_NONE,   8'h3C, 1'b0);
    endtask

    // Well-formed strings over a small symbol pool so prefixes are shared,
    // some mixed strings, some stray symbols and unused opcodes as noise.
    task automatic test_random_strings();
        logic [7:0] pool [4];
        logic [7:0] sym;
        int         bytes_done;
        int         len;
        t_op        op;
        bit         mixed;
        foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
        bytes_done = 0;
        while (bytes_done < 450) begin
            gapless = (bytes_done >= 180 && bytes_done < 260);
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                  : $urandom_range(1, 5);
            op      = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY;
            mixed   = ($urandom_range(0, 9) == 0);
            for (int b = 0; b < len; b++) begin
                if ($urandom_range(0, 19) == 0)
                    send_byte(OP_NONE, 8'($urandom), 1'($urandom));
                if (mixed)
                    op = t_op'($urandom_range(0, 1));
                sym = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                  : pool[$urandom_range(0, 3)];
                send_byte(op, sym, b == len - 1);
                bytes_done++;
            end
        end
        gapless = 1'b0;
    endtask

    task automatic test_table_full();
        logic [7:0] chain [$];
        int         guard;
        logic [7:0] sym;
        gapless = 1'b0;
        guard   = 0;
        // one long insert string; past the first bytes every byte needs a node
        while (nodes_taken < MAX_NODES && guard < 2 * MAX_NODES) begin
            sym = 8'($urandom);
            chain = {chain, sym};
            send_byte(OP_INSERT, sym, 1'b0);
            guard++;
        end
        send_byte(OP_INSERT, 8'($urandom), 1'b0);   // store exhausted
        send_byte(OP_QUERY,  chain[0],     1'b0);   // no walk after full
        send_byte(OP_INSERT, 8'($urandom), 1'b1);   // full status
        // existing edges still walk on a full store
        send_byte(OP_INSERT, chain[0], 1'b0);
        send_byte(OP_INSERT, chain[1], 1'b1);
        send_byte(OP_QUERY,  chain[0], 1'b1);
        send_byte(OP_QUERY,  chain[0], 1'b0);
        send_byte(OP_QUERY,  chain[1], 1'b0);
        send_byte(OP_QUERY,  chain[2], 1'b1);
        send_byte(OP_QUERY,  8'($urandom), 1'b1);
        send_byte(OP_INSERT, chain[0], 1'b0);
        send_byte(OP_INSERT, 8'($urandom), 1'b1);
        // clear part way through a string, then the trie starts empty
        send_byte(OP_INSERT, chain[0], 1'b0);
        send_byte(OP_CLEAR,  8'($urandom), 1'b1);
        send_byte(OP_QUERY,  chain[0], 1'b1);
        send_byte(OP_INSERT, chain[0], 1'b1);
        send_byte(OP_INSERT, chain[0], 1'b0);
        send_byte(OP_INSERT, chain[1], 1'b1);
        send_byte(OP_QUERY,  chain[0], 1'b1);
        send_byte(OP_QUERY,  chain[0], 1'b0);
        send_byte(OP_QUERY,  chain[1], 1'b1);
    endtask

    initial begin
        wipe_trie();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_strings();
        test_table_full();

        hold_off(1);
        while (pending_answers.size() != 0) @(posedge i_clk);
        // all expected results are in; a stray one would show during the wait below
        repeat (8) @(posedge i_clk);
        while (pending_answers.size() != 0) begin
            void'(pending_answers.pop_front());
            flag_error("expected result never arrived");
        end

        $display("Sent %0d transfers, checked %0d results (%0d table-full, %0d clears)",
                 sent_total, checked, full_seen, clears_seen);
        $display("Covered shared prefixes, misses, mixed strings, a full node store");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* trie_prefix_counter_top.f */
rtl/tpc_pkg.sv
rtl/tpc_front.sv
rtl/tpc_back.sv
rtl/trie_prefix_counter_top.sv
dv/trie_prefix_counter_top_tb.sv
